// ----- sv/gld_pkg.sv -----
// ----------------------------------------------------------------------------
// gld_pkg: shared types and constants for the GIF LZW pixel decoder
// Request and status codes, payload structs, register indexes.
// ----------------------------------------------------------------------------
package gld_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int DICT_ENTRIES  = 4096;
    localparam int STACK_DEPTH   = 4096;
    localparam int DICT_AW       = $clog2(DICT_ENTRIES);
    localparam int STACK_AW      = $clog2(STACK_DEPTH);

    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_PULL  = 2'd2;

    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_NEED    = 3'd1;
    localparam logic [2:0] ST_TAKEN   = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;
    localparam logic [2:0] ST_BAD     = 3'd5;

    localparam logic [2:0] REG_MIN    = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_ILACE  = 3'd3;
    localparam logic [2:0] REG_TEN    = 3'd4;
    localparam logic [2:0] REG_TIDX   = 3'd5;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  color_index;
        logic [15:0] pixel_x;
        logic [15:0] pixel_row;
        logic        is_transparent;
        logic        last_pixel;
    } t_out_item;

    function automatic logic [3:0] ilace_start(input logic [1:0] p);
        case (p)
            2'd0:    return 4'd0;
            2'd1:    return 4'd4;
            2'd2:    return 4'd2;
            default: return 4'd1;
        endcase
    endfunction

    function automatic logic [3:0] ilace_step(input logic [1:0] p);
        case (p)
            2'd0, 2'd1: return 4'd8;
            2'd2:       return 4'd4;
            default:    return 4'd2;
        endcase
    endfunction

endpackage

// ----- sv/gif_lzw_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder: GIF LZW data to pixel indices
// Bit unpacking, dictionary walk onto a string stack, and pixel pops.
// ----------------------------------------------------------------------------
// Timing: a begin or byte result is registered and offered in the cycle after the item
// is accepted; a pull that pops a waiting pixel passes through S_POPRD and S_POP; a pull
// that decodes adds S_GETCODE per code read plus S_WALKRD and S_WALK per dictionary step
// (registered prefix/suffix read). One item is in flight at a time; the next is taken
// in the cycle after the result leaves. Reset is synchronous, active low; dictionary
// and stack memories are not cleared, entries are written before read.
module gif_lzw_pixel_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  gld_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output gld_pkg::t_out_item  o_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);
    import gld_pkg::*;

    localparam logic [12:0] NO_CODE = 13'h1FFF;
    localparam logic [2:0] PH_IDLE = 3'd0, PH_RUN = 3'd1, PH_ENDED = 3'd2,
                           PH_DONE = 3'd3, PH_FAIL = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE, S_GETCODE, S_WALKRD, S_WALK, S_POPRD, S_POP, S_OUT
    } t_state;

    // configuration registers
    logic [3:0]  r_min;
    logic [15:0] r_w, r_h;
    logic        r_ilace, r_ten;
    logic [7:0]  r_tidx;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 4'd8; r_w <= 16'd1; r_h <= 16'd1;
            r_ilace <= 1'b0; r_ten <= 1'b0; r_tidx <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MIN:    r_min   <= i_cfg_data[3:0];
                REG_WIDTH:  r_w     <= i_cfg_data;
                REG_HEIGHT: r_h     <= i_cfg_data;
                REG_ILACE:  r_ilace <= i_cfg_data[0];
                REG_TEN:    r_ten   <= i_cfg_data[0];
                REG_TIDX:   r_tidx  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    logic [3:0] emin;
    assign emin = (r_min < 4'd2) ? 4'd2 : ((r_min > 4'd8) ? 4'd8 : r_min);
    logic [12:0] clear;
    assign clear = 13'd1 << emin;

    t_state      r_state;
    logic [2:0]  r_phase;
    logic [12:0] r_sp;
    logic [23:0] r_buf;
    logic [4:0]  r_cnt;
    logic [7:0]  r_left;
    logic [3:0]  r_cw;
    logic [12:0] r_nfc, r_prev, r_incode, r_code;
    logic [7:0]  r_pfc;
    t_out_item   r_out;
    logic        r_ovalid;

    // memories
    logic            d_we, s_we;
    logic [11:0]     d_waddr, d_raddr, s_waddr, s_raddr;
    logic [11:0]     d_wpre, d_rpre;
    logic [7:0]      d_wsuf, d_rsuf, s_wdata, s_rdata;

    gld_ram #(.WIDTH(12), .DEPTH(DICT_ENTRIES)) u_pre (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wpre),
        .i_raddr(d_raddr), .o_rdata(d_rpre));
    gld_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suf (
        .i_clk, .i_we(d_we), .i_waddr(d_waddr), .i_wdata(d_wsuf),
        .i_raddr(d_raddr), .o_rdata(d_rsuf));
    gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk (
        .i_clk, .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));

    // position tracker
    logic        pos_clear, pos_adv, pos_last;
    logic [15:0] pos_col, pos_row;
    gld_pos u_pos (
        .i_clk, .i_rst_n, .i_clear(pos_clear), .i_advance(pos_adv),
        .i_width(r_w), .i_height(r_h), .i_ilace(r_ilace),
        .o_col(pos_col), .o_row(pos_row), .o_last(pos_last));

    wire in_acc = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // code extraction
    logic [11:0] cmask, code_now;
    assign cmask    = 12'((13'd1 << r_cw) - 13'd1);
    assign code_now = r_buf[11:0] & cmask;

    assign d_raddr = r_code[11:0];
    assign s_raddr = 12'(r_sp - 13'd1);
    assign pos_clear = in_acc && i_item.req_type == REQ_BEGIN;
    assign pos_adv   = (r_state == S_POP);

    logic [7:0] first;
    assign first = r_code[7:0];

    // stack and dictionary write strobes
    always_comb begin
        s_we = 1'b0; s_waddr = r_sp[11:0]; s_wdata = 8'd0;
        d_we = 1'b0; d_waddr = r_nfc[11:0]; d_wpre = r_prev[11:0]; d_wsuf = first;
        case (r_state)
            S_GETCODE: begin
                if (r_cnt >= {1'b0, r_cw} && {1'b0, code_now} != clear
                    && {1'b0, code_now} != clear + 13'd1
                    && {1'b0, code_now} == r_nfc && r_prev != NO_CODE
                    && r_sp < 13'(STACK_DEPTH)) begin
                    s_we = 1'b1; s_wdata = r_pfc;
                end
            end
            S_WALK: begin
                if (r_code >= clear) begin
                    s_we = r_sp < 13'(STACK_DEPTH); s_wdata = d_rsuf;
                end else if (r_sp < 13'(STACK_DEPTH)) begin
                    s_we = 1'b1; s_wdata = first;
                    d_we = r_prev != NO_CODE && r_nfc < 13'(DICT_ENTRIES);
                end
            end
            default: ;
        endcase
    end

    function automatic t_out_item st(input logic [2:0] s);
        t_out_item o;
        o = '0; o.status = s;
        return o;
    endfunction

    // main sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_phase <= PH_IDLE; r_ovalid <= 1'b0;
            r_sp <= '0; r_buf <= '0; r_cnt <= '0; r_left <= '0;
            r_cw <= 4'd9; r_nfc <= 13'd258; r_prev <= NO_CODE; r_pfc <= '0;
            r_code <= '0; r_incode <= '0; r_out <= '0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_item.req_type)
                            REQ_BEGIN: begin
                                r_sp <= '0; r_buf <= '0; r_cnt <= '0; r_left <= '0;
                                r_cw <= emin + 4'd1; r_nfc <= clear + 13'd2;
                                r_prev <= NO_CODE; r_pfc <= '0; r_phase <= PH_RUN;
                                r_out <= st(ST_TAKEN); r_ovalid <= 1'b1;
                            end
                            REQ_BYTE: begin
                                r_ovalid <= 1'b1;
                                if (r_phase != PH_RUN) begin
                                    r_out <= st(ST_REFUSED);
                                end else if (r_left == 8'd0) begin
                                    if (i_item.data_byte == 8'd0) r_phase <= PH_ENDED;
                                    else r_left <= i_item.data_byte;
                                    r_out <= st(ST_TAKEN);
                                end else if (r_cnt > 5'd16) begin
                                    r_out <= st(ST_REFUSED);
                                end else begin
                                    r_buf <= r_buf | ({16'd0, i_item.data_byte} << r_cnt);
                                    r_cnt <= r_cnt + 5'd8;
                                    r_left <= r_left - 8'd1;
                                    r_out <= st(ST_TAKEN);
                                end
                            end
                            REQ_PULL: begin
                                if (r_phase == PH_IDLE || r_phase == PH_DONE) begin
                                    r_out <= st(ST_DONE); r_ovalid <= 1'b1;
                                end else if (r_phase == PH_FAIL) begin
                                    r_out <= st(ST_BAD); r_ovalid <= 1'b1;
                                end else if (r_sp != 13'd0) begin
                                    r_state <= S_POPRD;
                                end else begin
                                    r_state <= S_GETCODE;
                                end
                            end
                            default: begin
                                r_out <= st(ST_DONE); r_ovalid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_GETCODE: begin
                    if (r_cnt < {1'b0, r_cw}) begin
                        if (r_phase == PH_ENDED) begin
                            r_phase <= PH_DONE; r_out <= st(ST_DONE);
                        end else begin
                            r_out <= st(ST_NEED);
                        end
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else begin
                        r_buf <= r_buf >> r_cw;
                        r_cnt <= r_cnt - {1'b0, r_cw};
                        if ({1'b0, code_now} == clear) begin
                            r_cw <= emin + 4'd1; r_nfc <= clear + 13'd2; r_prev <= NO_CODE;
                        end else if ({1'b0, code_now} == clear + 13'd1) begin
                            r_phase <= PH_DONE; r_out <= st(ST_DONE);
                            r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else if ({1'b0, code_now} >= r_nfc) begin
                            if (r_prev == NO_CODE || {1'b0, code_now} != r_nfc
                                || r_sp >= 13'(STACK_DEPTH)) begin
                                r_sp <= '0; r_phase <= PH_FAIL; r_out <= st(ST_BAD);
                                r_ovalid <= 1'b1; r_state <= S_IDLE;
                            end else begin
                                r_sp <= r_sp + 13'd1;
                                r_incode <= {1'b0, code_now};
                                r_code <= r_prev; r_state <= S_WALKRD;
                            end
                        end else begin
                            r_incode <= {1'b0, code_now};
                            r_code <= {1'b0, code_now}; r_state <= S_WALKRD;
                        end
                    end
                end
                S_WALKRD: r_state <= S_WALK;
                S_WALK: begin
                    if (r_sp >= 13'(STACK_DEPTH)) begin
                        r_sp <= '0; r_phase <= PH_FAIL; r_out <= st(ST_BAD);
                        r_ovalid <= 1'b1; r_state <= S_IDLE;
                    end else if (r_code >= clear) begin
                        r_sp <= r_sp + 13'd1;
                        r_code <= {1'b0, d_rpre}; r_state <= S_WALKRD;
                    end else begin
                        r_sp <= r_sp + 13'd1;
                        if (r_prev != NO_CODE && r_nfc < 13'(DICT_ENTRIES)) begin
                            r_nfc <= r_nfc + 13'd1;
                            if ((r_nfc + 13'd1) >= (13'd1 << r_cw)
                                && r_cw < 4'(MAX_CODE_BITS)) begin
                                r_cw <= r_cw + 4'd1;
                            end
                        end
                        r_prev <= r_incode; r_pfc <= first;
                        r_state <= S_POPRD;
                    end
                end
                S_POPRD: r_state <= S_POP;
                S_POP: begin
                    r_out.status <= ST_PIXEL;
                    r_out.color_index <= s_rdata;
                    r_out.pixel_x <= pos_col;
                    r_out.pixel_row <= pos_row;
                    r_out.is_transparent <= r_ten && s_rdata == r_tidx;
                    r_out.last_pixel <= pos_last;
                    if (pos_last) begin
                        r_sp <= '0; r_phase <= PH_DONE;
                    end else begin
                        r_sp <= r_sp - 13'd1;
                    end
                    r_ovalid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- sv/gld_ram.sv -----
// ----------------------------------------------------------------------------
// gld_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/gld_pos.sv -----
// ----------------------------------------------------------------------------
// gld_pos: pixel position tracker
// Keeps column, row and interlace pass; steps one pixel per advance.
// ----------------------------------------------------------------------------
module gld_pos (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clear,
    input  logic        i_advance,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    input  logic        i_ilace,
    output logic [15:0] o_col,
    output logic [15:0] o_row,
    output logic        o_last
);
    import gld_pkg::*;

    logic [15:0] r_col, r_row;
    logic [1:0]  r_pass;
    logic [15:0] w, h;
    logic [17:0] row_a, row_b, row_c, row_d;
    logic [1:0]  pass_n;
    logic [17:0] row_n;

    assign w = (i_width == 16'd0) ? 16'd1 : i_width;
    assign h = (i_height == 16'd0) ? 16'd1 : i_height;

    // work out the next row at end of line, walking at most three passes
    always_comb begin
        row_a  = {2'b00, r_row} + {14'd0, ilace_step(r_pass)};
        pass_n = r_pass;
        row_n  = row_a;
        row_b  = {14'd0, ilace_start(2'd1)};
        row_c  = {14'd0, ilace_start(2'd2)};
        row_d  = {14'd0, ilace_start(2'd3)};
        if (!i_ilace) begin
            row_n = {2'b00, r_row} + 18'd1;
        end else if (row_a >= {2'b00, h} && r_pass < 2'd3) begin
            if (r_pass == 2'd0 && row_b < {2'b00, h}) begin
                pass_n = 2'd1; row_n = row_b;
            end else if (r_pass <= 2'd1 && row_c < {2'b00, h}) begin
                pass_n = 2'd2; row_n = row_c;
            end else begin
                pass_n = 2'd3; row_n = row_d;
            end
        end
    end

    wire eol = ({1'b0, r_col} + 17'd1) >= {1'b0, w};
    assign o_last = eol && (row_n >= {2'b00, h});
    assign o_col  = r_col;
    assign o_row  = r_row;

    // step position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pass <= '0;
        end else if (i_advance) begin
            if (eol) begin
                r_col  <= '0;
                r_pass <= pass_n;
                if (!o_last) begin
                    r_row <= row_n[15:0];
                end
            end else begin
                r_col <= r_col + 16'd1;
            end
        end
    end
endmodule

// ----- tb/gif_lzw_pixel_decoder_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder_checker: pixel predictor and result comparator
// Watches the request, result and register channels of the decoder. It keeps
// its own copy of the LZW state and registers and predicts one result per
// accepted item. Each accepted result is compared field by field.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  gld_pkg::t_in_item  i_req_item,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  gld_pkg::t_out_item i_res_item,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_pixels
);
    import gld_pkg::*;

    localparam int unsigned NO_PREV = 32'h1FFF;

    typedef enum logic [2:0] {
        PH_IDLE, PH_RUN, PH_ENDED, PH_DONE, PH_FAIL
    } t_phase;

    // Register copies
    logic [3:0]  reg_min;
    logic [15:0] reg_width;
    logic [15:0] reg_height;
    logic        reg_ilace;
    logic        reg_ten;
    logic [7:0]  reg_tidx;

    // Decoder state copies
    logic [11:0] prefix_mem [DICT_ENTRIES];
    logic [7:0]  suffix_mem [DICT_ENTRIES];
    logic [7:0]  string_mem [STACK_DEPTH];
    int unsigned sp, bitbuf, bitcnt, blk_left, cw, nf, prev_code, prev_first;
    int unsigned col, row, ipass;
    t_phase      phase;

    t_out_item   expected_pixels [$];

    function automatic int unsigned clamped_min();
        int unsigned m;
        m = reg_min;
        if (m < 2) m = 2;
        if (m > 8) m = 8;
        return m;
    endfunction

    function automatic void restart_codes();
        cw = clamped_min() + 1;
        nf = (1 << clamped_min()) + 2;
        prev_code = NO_PREV;
    endfunction

    function automatic void start_image();
        sp = 0; bitbuf = 0; bitcnt = 0; blk_left = 0;
        restart_codes();
        prev_first = 0; col = 0; row = 0; ipass = 0;
    endfunction

    function automatic bit push_char(int unsigned v);
        if (sp >= STACK_DEPTH) return 1'b0;
        string_mem[sp] = v[7:0];
        sp++;
        return 1'b1;
    endfunction

    // Walk one code onto the string stack; 0 on a bad code
    function automatic bit expand_code(int unsigned code, int unsigned clr);
        int unsigned in_code, first;
        in_code = code;
        if (code >= DICT_ENTRIES) return 1'b0;
        if (code >= nf) begin
            // code not yet defined: previous string plus its first char
            if (prev_code == NO_PREV || code != nf) return 1'b0;
            if (!push_char(prev_first)) return 1'b0;
            code = prev_code;
        end
        while (code >= clr) begin
            if (!push_char(suffix_mem[code])) return 1'b0;
            code = prefix_mem[code];
        end
        first = code & 8'hFF;
        if (!push_char(first)) return 1'b0;
        if (prev_code != NO_PREV && nf < DICT_ENTRIES) begin
            prefix_mem[nf] = prev_code[11:0];
            suffix_mem[nf] = first[7:0];
            nf++;
            if (nf >= (1 << cw) && cw < MAX_CODE_BITS) cw++;
        end
        prev_code = in_code;
        prev_first = first;
        return 1'b1;
    endfunction

    function automatic t_out_item predict_result(t_in_item it);
        t_out_item   r;
        int unsigned clr, code, w, h, nrow, color;
        bit          last;
        r = '0;
        last = 1'b0;
        clr = 1 << clamped_min();
        if (it.req_type == REQ_BEGIN) begin
            start_image();
            phase = PH_RUN;
            r.status = ST_TAKEN;
            return r;
        end
        if (it.req_type == REQ_BYTE) begin
            if (phase != PH_RUN) begin
                r.status = ST_REFUSED;
                return r;
            end
            if (blk_left == 0) begin
                if (it.data_byte == 0) phase = PH_ENDED;
                else blk_left = it.data_byte;
                r.status = ST_TAKEN;
                return r;
            end
            if (bitcnt > 16) begin
                r.status = ST_REFUSED;
                return r;
            end
            bitbuf = (bitbuf | (int'(it.data_byte) << bitcnt)) & 24'hFFFFFF;
            bitcnt += 8;
            blk_left--;
            r.status = ST_TAKEN;
            return r;
        end
        if (it.req_type != REQ_PULL || phase == PH_IDLE || phase == PH_DONE) begin
            r.status = ST_DONE;
            return r;
        end
        if (phase == PH_FAIL) begin
            r.status = ST_BAD;
            return r;
        end
        // Refill the stack from the bit buffer until a string is ready
        while (sp == 0) begin
            if (bitcnt < cw) begin
                if (phase == PH_ENDED) begin
                    phase = PH_DONE;
                    r.status = ST_DONE;
                end else begin
                    r.status = ST_NEED;
                end
                return r;
            end
            code = bitbuf & ((1 << cw) - 1);
            bitbuf >>= cw;
            bitcnt -= cw;
            if (code == clr) begin
                restart_codes();
                continue;
            end
            if (code == clr + 1) begin
                phase = PH_DONE;
                r.status = ST_DONE;
                return r;
            end
            if (!expand_code(code, clr)) begin
                sp = 0;
                phase = PH_FAIL;
                r.status = ST_BAD;
                return r;
            end
        end
        // Pop one pixel and advance the raster position
        sp--;
        color = string_mem[sp];
        r.status = ST_PIXEL;
        r.color_index = color[7:0];
        r.pixel_x = col[15:0];
        r.pixel_row = row[15:0];
        r.is_transparent = reg_ten && (color[7:0] == reg_tidx);
        w = (reg_width != 0) ? reg_width : 1;
        h = (reg_height != 0) ? reg_height : 1;
        col++;
        if (col >= w) begin
            col = 0;
            nrow = row;
            if (reg_ilace) begin
                nrow += ilace_step(ipass[1:0]);
                while (nrow >= h && ipass < 3) begin
                    ipass++;
                    nrow = ilace_start(ipass[1:0]);
                end
            end else begin
                nrow++;
            end
            if (nrow >= h) last = 1'b1;
            else row = nrow;
        end
        if (last) begin
            r.last_pixel = 1'b1;
            sp = 0;
            phase = PH_DONE;
        end
        return r;
    endfunction

    function automatic int field_bad(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v == act_v) return 0;
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        return 1;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge i_clk) begin
        t_out_item want;
        int        bad;
        if (!i_rst_n) begin
            reg_min <= 4'd8;
            reg_width <= 16'd1;
            reg_height <= 16'd1;
            reg_ilace <= 1'b0;
            reg_ten <= 1'b0;
            reg_tidx <= 8'd0;
            sp = 0; bitbuf = 0; bitcnt = 0; blk_left = 0;
            cw = 9; nf = 258; prev_code = NO_PREV; prev_first = 0;
            col = 0; row = 0; ipass = 0;
            phase = PH_IDLE;
            expected_pixels.delete();
            o_errors <= 0;
            o_pixels <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN:    reg_min <= i_cfg_data[3:0];
                    REG_WIDTH:  reg_width <= i_cfg_data;
                    REG_HEIGHT: reg_height <= i_cfg_data;
                    REG_ILACE:  reg_ilace <= i_cfg_data[0];
                    REG_TEN:    reg_ten <= i_cfg_data[0];
                    REG_TIDX:   reg_tidx <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                expected_pixels.push_back(predict_result(i_req_item));
            if (i_res_valid && i_res_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result arrived with nothing expected, status %0d",
                           i_res_item.status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    bad = field_bad("status", want.status, i_res_item.status)
                        + field_bad("color_index", want.color_index, i_res_item.color_index)
                        + field_bad("pixel_x", want.pixel_x, i_res_item.pixel_x)
                        + field_bad("pixel_row", want.pixel_row, i_res_item.pixel_row)
                        + field_bad("is_transparent", want.is_transparent,
                                    i_res_item.is_transparent)
                        + field_bad("last_pixel", want.last_pixel, i_res_item.last_pixel);
                    o_errors <= o_errors + bad;
                    if (want.status == ST_PIXEL) o_pixels <= o_pixels + 1;
                end
            end
        end
    end

    assign o_pending = expected_pixels.size();

endmodule

// ----- tb/gif_lzw_pixel_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder_tb: stimulus and verdict for the GIF LZW decoder
// Builds LZW code streams (clear, literals, known strings, the not-yet-defined
// code, end), frames them into sub-blocks and feeds them with pulls under
// random idling on both sides. The checker predicts and compares.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder_tb;
    import gld_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int          errors, pending, pixels;
    int          n_results = 0;
    logic [2:0]  last_status = '0;
    int          stall_left = 0;
    int          cycles = 0;
    int          n_items = 0;
    int          n_images = 0;
    bit          quiet = 1'b0;

    // Code stream builder state
    int unsigned gen_min, gen_clr, gen_cw, gen_nf, gen_acc, gen_nbits;
    bit          gen_prev;
    logic [7:0]  code_bytes [$];
    logic [7:0]  data_stream [$];

    gif_lzw_pixel_decoder uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready), .i_item(in_item),
        .o_valid(out_valid), .i_ready(out_ready), .o_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    gif_lzw_pixel_decoder_checker chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_req_valid(in_valid), .i_req_ready(in_ready), .i_req_item(in_item),
        .i_res_valid(out_valid), .i_res_ready(out_ready), .i_res_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_pixels(pixels)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Result side: random stall bursts, none in the quiet tail
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            n_results <= n_results + 1;
            last_status <= out_item.status;
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Send one item and wait for its result
    task automatic send_item(input logic [1:0] kind, input logic [7:0] value,
                             output logic [2:0] status);
        int want;
        if (!quiet && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 18)) @(posedge clk);
        want = n_results + 1;
        in_valid <= 1'b1;
        in_item <= '{req_type: kind, data_byte: value};
        do @(posedge clk); while (!in_ready);
        in_valid <= 1'b0;
        n_items++;
        while (n_results < want) @(posedge clk);
        status = last_status;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Settle, then program all registers
    task automatic set_image(input int unsigned m, input int unsigned w, input int unsigned h,
                             input bit il, input bit ten, input int unsigned tidx);
        repeat (8) @(posedge clk);
        write_reg(REG_MIN, 16'(m));
        write_reg(REG_WIDTH, 16'(w));
        write_reg(REG_HEIGHT, 16'(h));
        write_reg(REG_ILACE, 16'(il));
        write_reg(REG_TEN, 16'(ten));
        write_reg(REG_TIDX, 16'(tidx));
    endtask

    function automatic void restart_gen();
        gen_cw = gen_min + 1;
        gen_nf = gen_clr + 2;
        gen_prev = 1'b0;
    endfunction

    function automatic void open_stream(input int unsigned m);
        gen_min = (m < 2) ? 2 : (m > 8) ? 8 : m;
        gen_clr = 1 << gen_min;
        restart_gen();
        gen_acc = 0;
        gen_nbits = 0;
        code_bytes.delete();
    endfunction

    // Pack one code LSB first and track the dictionary growth it causes
    function automatic void put_code(input int unsigned code);
        gen_acc |= code << gen_nbits;
        gen_nbits += gen_cw;
        while (gen_nbits >= 8) begin
            code_bytes.push_back(gen_acc[7:0]);
            gen_acc >>= 8;
            gen_nbits -= 8;
        end
        if (code == gen_clr) begin
            restart_gen();
        end else if (code != gen_clr + 1) begin
            if (gen_prev && gen_nf < DICT_ENTRIES) begin
                gen_nf++;
                if (gen_nf >= (1 << gen_cw) && gen_cw < MAX_CODE_BITS) gen_cw++;
            end
            gen_prev = 1'b1;
        end
    endfunction

    // Flush bits and cut into sub-blocks, closed by a zero length
    function automatic void close_stream(input int unsigned max_blk);
        int i, n;
        if (gen_nbits > 0) code_bytes.push_back(gen_acc[7:0]);
        data_stream.delete();
        i = 0;
        while (i < code_bytes.size()) begin
            n = $urandom_range(1, max_blk);
            if (n > code_bytes.size() - i) n = code_bytes.size() - i;
            data_stream.push_back(n[7:0]);
            repeat (n) begin
                data_stream.push_back(code_bytes[i]);
                i++;
            end
        end
        data_stream.push_back(8'd0);
    endfunction

    // Random well-formed codes: literals, known strings, the next code, clears
    function automatic void random_codes(input int n, input int lit_pct, input int clr_pct);
        int r;
        put_code(gen_clr);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < clr_pct)
                put_code(gen_clr);
            else if (r < lit_pct || !gen_prev)
                put_code($urandom_range(0, gen_clr - 1));
            else if (r < lit_pct + 6 && gen_nf < DICT_ENTRIES)
                put_code(gen_nf);
            else if (gen_nf > gen_clr + 2)
                put_code($urandom_range(gen_clr + 2, gen_nf - 1));
            else
                put_code($urandom_range(0, gen_clr - 1));
        end
        if ($urandom_range(0, 9) != 0) put_code(gen_clr + 1);
    endfunction

    // Begin, then feed bytes and pulls until the image ends, fails or runs out of data
    task automatic play_image(input bit eager);
        logic [2:0] st;
        int         idx;
        bit         need;
        send_item(REQ_BEGIN, 8'($urandom_range(0, 255)), st);
        n_images++;
        idx = 0;
        need = 1'b0;
        while (1) begin
            if (idx < data_stream.size() && (need || eager || $urandom_range(0, 4) == 0)) begin
                send_item(REQ_BYTE, data_stream[idx], st);
                if (st == ST_TAKEN) idx++;
                else eager = 1'b0;
                need = 1'b0;
            end else begin
                send_item(REQ_PULL, 8'($urandom_range(0, 255)), st);
                if (st == ST_DONE || st == ST_BAD) break;
                if (st == ST_NEED) begin
                    if (idx >= data_stream.size()) break;
                    need = 1'b1;
                end
            end
        end
    endtask

    task automatic random_image(input int max_codes);
        set_image($urandom_range(2, 8), $urandom_range(1, 40), $urandom_range(1, 40),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 255));
        open_stream(chk.reg_min);
        random_codes($urandom_range(1, max_codes), 70, 3);
        close_stream($urandom_range(1, 30));
        play_image($urandom_range(0, 7) == 0);
    endtask

    initial begin
        logic [2:0] st;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pull and byte before any image
        send_item(REQ_PULL, 8'h00, st);
        send_item(REQ_BYTE, 8'hFF, st);

        // Min size below range, the not-yet-defined code, transparent pixels
        set_image(0, 4, 1, 1'b0, 1'b1, 3);
        open_stream(2);
        put_code(gen_clr);
        put_code(3);
        put_code(gen_nf);
        put_code(gen_clr + 1);
        close_stream(2);
        play_image(1'b1);
        send_item(REQ_BYTE, 8'h01, st);

        // Min size above range, zero width and height, bytes until buffer is full
        set_image(15, 0, 0, 1'b1, 1'b0, 255);
        open_stream(8);
        put_code(gen_clr);
        put_code(255);
        put_code(gen_clr + 1);
        close_stream(255);
        play_image(1'b1);
        send_item(REQ_PULL, 8'h80, st);

        // Undefined code right after a clear, then a pull after the failure
        set_image(4, 3, 2, 1'b0, 1'b0, 0);
        open_stream(4);
        put_code(gen_clr);
        put_code(gen_clr + 2);
        close_stream(4);
        play_image(1'b0);
        send_item(REQ_PULL, 8'h7F, st);

        // Data runs out without an end code
        open_stream(4);
        put_code(gen_clr);
        put_code(9);
        close_stream(4);
        play_image(1'b0);

        // Random images of varied size and register settings
        while (n_items < 500) random_image(40);

        // Grow the code width: long image, no clears, mostly literals
        set_image(2, 16, 16, 1'($urandom_range(0, 1)), 1'b1, 2);
        open_stream(2);
        random_codes(150, 90, 0);
        close_stream(255);
        play_image(1'b0);

        // Largest image size, interlaced
        set_image(8, 65535, 65535, 1'b1, 1'b1, 16'h00AA);
        open_stream(8);
        random_codes(30, 70, 2);
        close_stream(255);
        play_image(1'b0);

        // Unstructured noise items
        repeat (60) send_item(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), st);

        // Tail with no idling on either side
        quiet = 1'b1;
        repeat (2) random_image(40);

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("covered %0d items over %0d images, %0d pixels checked",
                 n_items, n_images, pixels);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
